>>> rtl/bgu_pkg.sv
package bgu_pkg;

  localparam int SOURCE_SIZE = 24;
  localparam int MAX_FACTOR  = 3;
  localparam int CHUNK_BITS  = 12;
  localparam int ROW_W       = SOURCE_SIZE;
  localparam int FACTOR_W    = 2;
  localparam int SRC_CNT_W   = 5;
  localparam int OROW_W      = 7;
  localparam int NROWS_W     = 3;
  localparam int CHUNK_IDX_W = 4;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  typedef enum logic [0:0] {
    REG_X_FACTOR = 1'b0,
    REG_Y_FACTOR = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [ROW_W-1:0]    row_bits;
    logic [FACTOR_W-1:0] xf;
    logic [NROWS_W-1:0]  nrows;
    logic                img_last;
  } q_entry_t;

  function automatic logic [FACTOR_W-1:0] eff_factor(input logic [FACTOR_W-1:0] f);
    logic [FACTOR_W-1:0] r;
    r = f;
    if (r < FACTOR_W'(1)) r = FACTOR_W'(1);
    if (r > FACTOR_W'(MAX_FACTOR)) r = FACTOR_W'(MAX_FACTOR);
    return r;
  endfunction

  function automatic logic [3:0] times3(input logic [FACTOR_W-1:0] f);
    return 4'(f) * 4'd3;
  endfunction

  function automatic logic [7:0] div3(input logic [7:0] x);
    logic [15:0] p;
    p = 16'(x) * 16'd171;
    return 8'(p >> 9);
  endfunction

  function automatic logic [CHUNK_BITS-1:0] scale_chunk(
    input logic [ROW_W-1:0]       row,
    input logic [FACTOR_W-1:0]    xf,
    input logic [CHUNK_IDX_W-1:0] c
  );
    logic [CHUNK_BITS-1:0] chunk;
    logic [7:0]            j;
    logic [7:0]            t;
    logic [4:0]            sc;
    chunk = '0;
    for (int b = 0; b < CHUNK_BITS; b++) begin
      j = 8'(c) * 8'(CHUNK_BITS) + 8'(b);
      t = div3(j << 1);
      unique case (xf)
        2'd2:    sc = 5'(div3(j));
        2'd3:    sc = 5'(div3(t));
        default: sc = 5'(t);
      endcase
      chunk[CHUNK_BITS-1-b] = row[5'(SOURCE_SIZE-1) - sc];
    end
    return chunk;
  endfunction

endpackage

>>> rtl/bgu_if.sv
interface bgu_in_if import bgu_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_bits;

  modport source (output valid, output row_bits, input ready);
  modport sink   (input valid, input row_bits, output ready);
endinterface

interface bgu_out_if import bgu_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CHUNK_BITS-1:0] pixel_chunk;
  logic                  row_end;
  logic                  image_end;
  logic                  last;

  modport source (output valid, output pixel_chunk, output row_end, output image_end,
                  output last, input ready);
  modport sink   (input valid, input pixel_chunk, input row_end, input image_end,
                  input last, output ready);
endinterface

>>> rtl/bgu_front.sv
module bgu_front import bgu_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  bgu_in_if.sink              in_ch,
  input  logic [FACTOR_W-1:0] x_eff,
  input  logic [FACTOR_W-1:0] y_eff,
  input  logic                q_full,
  output logic                push,
  output q_entry_t            push_data
);

  logic [SRC_CNT_W-1:0] src_cnt_r, src_cnt_nxt;
  logic [3:0]           p;
  logic [7:0]           a, b;
  logic [OROW_W-1:0]    first, endv, total, end_c;
  logic                 img_last;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    p        = times3(y_eff);
    a        = 8'(p) * 8'(src_cnt_r);
    b        = a + 8'(p);
    first    = OROW_W'((9'(a) + 9'd1) >> 1);
    endv     = OROW_W'((9'(b) + 9'd1) >> 1);
    total    = OROW_W'(p) * OROW_W'(CHUNK_BITS);
    end_c    = (endv > total) ? total : endv;
    img_last = (src_cnt_r == SRC_CNT_W'(SOURCE_SIZE-1));

    push_data.row_bits = in_ch.row_bits;
    push_data.xf       = x_eff;
    push_data.nrows    = NROWS_W'(end_c - first);
    push_data.img_last = img_last;

    src_cnt_nxt = src_cnt_r;
    if (push) begin
      src_cnt_nxt = img_last ? '0 : src_cnt_r + SRC_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cnt_r <= '0;
    end else begin
      src_cnt_r <= src_cnt_nxt;
    end
  end

endmodule

>>> rtl/bgu_queue.sv
module bgu_queue import bgu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  input  logic     pop,
  output q_entry_t pop_data,
  output logic     full,
  output logic     empty
);

  q_entry_t   mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    if (pop && !push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue pop while empty");
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

>>> rtl/bgu_back.sv
module bgu_back import bgu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  q_entry_t q_data,
  output logic     pop,
  bgu_out_if.source out_ch
);

  q_entry_t              ent_r;
  logic                  busy_r, busy_nxt;
  logic [NROWS_W-1:0]    ridx_r, ridx_nxt;
  logic [CHUNK_IDX_W-1:0] cidx_r, cidx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CHUNK_BITS-1:0] pixel_r;
  logic                  row_end_r, image_end_r, last_r;
  logic                  slot_free, emit, row_end, last;
  logic [CHUNK_IDX_W-1:0] nchunks;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_chunk = pixel_r;
  assign out_ch.row_end     = row_end_r;
  assign out_ch.image_end   = image_end_r;
  assign out_ch.last        = last_r;

  always_comb begin
    nchunks   = times3(ent_r.xf);
    slot_free = !out_valid_r || out_ch.ready;
    emit      = busy_r && slot_free;
    pop       = !busy_r && !q_empty;
    row_end   = (cidx_r == nchunks - CHUNK_IDX_W'(1));
    last      = row_end && (ridx_r == ent_r.nrows - NROWS_W'(1));

    busy_nxt      = busy_r;
    ridx_nxt      = ridx_r;
    cidx_nxt      = cidx_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;

    if (pop) begin
      busy_nxt = 1'b1;
      ridx_nxt = '0;
      cidx_nxt = '0;
    end else if (emit) begin
      out_valid_nxt = 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
      end else if (row_end) begin
        ridx_nxt = ridx_r + NROWS_W'(1);
        cidx_nxt = '0;
      end else begin
        cidx_nxt = cidx_r + CHUNK_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r <= q_data;
    end
    if (emit) begin
      pixel_r     <= scale_chunk(ent_r.row_bits, ent_r.xf, cidx_r);
      row_end_r   <= row_end;
      image_end_r <= last && ent_r.img_last;
      last_r      <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      ridx_r      <= '0;
      cidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      ridx_r      <= ridx_nxt;
      cidx_r      <= cidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/bitmap_glyph_upscaler_top.sv
// The first chunk of a row is registered in the queue, the back-end entry register
// and the output register. Throughput: 3*x_eff chunks per output row, 1 to 5 output
// rows per source row, one chunk per cycle from the back-end chunk generator while
// the output is not stalled, plus a load of each queued row before its chunks.
// Reset (synchronous, active low): both factors 2, source row counter 0, queue
// and output register empty.
module bitmap_glyph_upscaler_top import bgu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  bgu_in_if.sink             in_ch,
  bgu_out_if.source          out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready
);

  logic [FACTOR_W-1:0] x_factor_r, y_factor_r;
  logic [FACTOR_W-1:0] x_eff, y_eff;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;
  logic                push, pop, q_full, q_empty;
  q_entry_t            push_data, pop_data;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign x_eff      = eff_factor(x_factor_r);
  assign y_eff      = eff_factor(y_factor_r);

  always_comb begin
    unique case (cfg_idx)
      REG_X_FACTOR: cfg_prdata = PDATA_W'(x_factor_r);
      REG_Y_FACTOR: cfg_prdata = PDATA_W'(y_factor_r);
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_factor_r <= FACTOR_W'(2);
      y_factor_r <= FACTOR_W'(2);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_X_FACTOR: x_factor_r <= cfg_pwdata[FACTOR_W-1:0];
        REG_Y_FACTOR: y_factor_r <= cfg_pwdata[FACTOR_W-1:0];
        default:      ;
      endcase
    end
  end

  bgu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .x_eff     (x_eff),
    .y_eff     (y_eff),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  bgu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  bgu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (pop_data),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
  import bgu_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_CHUNKS  = 45;
  localparam int DIR_ROWS    = 25;
  localparam int RAND_ROWS   = 245;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 50;

  localparam logic [PADDR_W-1:0] ADDR_X = PADDR_W'(4 * int'(REG_X_FACTOR));
  localparam logic [PADDR_W-1:0] ADDR_Y = PADDR_W'(4 * int'(REG_Y_FACTOR));

  typedef struct packed {
    logic [CHUNK_BITS-1:0] pixel_chunk;
    logic                  row_end;
    logic                  image_end;
    logic                  last;
  } chunk_t;

  typedef struct packed {
    logic [FACTOR_W-1:0]   xf;
    logic [FACTOR_W-1:0]   yf;
    logic [ROW_W-1:0]      row;
    logic                  fixed;
    logic [CHUNK_BITS-1:0] chunk;
  } glyph_row_t;

  glyph_row_t dir_tab [DIR_ROWS] = '{
    '{2'd2, 2'd2, 24'h000000, 1'b1, 12'h000},
    '{2'd2, 2'd2, 24'hFFFFFF, 1'b1, 12'hFFF},
    '{2'd2, 2'd2, 24'h800000, 1'b0, 12'h000},
    '{2'd2, 2'd2, 24'h000001, 1'b0, 12'h000},
    '{2'd3, 2'd3, 24'hFFFFFF, 1'b1, 12'hFFF},
    '{2'd3, 2'd3, 24'h000000, 1'b1, 12'h000},
    '{2'd3, 2'd3, 24'hA5C3F0, 1'b0, 12'h000},
    '{2'd1, 2'd1, 24'hFFFFFF, 1'b1, 12'hFFF},
    '{2'd1, 2'd1, 24'h123456, 1'b0, 12'h000},
    '{2'd0, 2'd0, 24'hFFFFFF, 1'b1, 12'hFFF},
    '{2'd0, 2'd0, 24'h800001, 1'b0, 12'h000},
    '{2'd0, 2'd3, 24'h555555, 1'b0, 12'h000},
    '{2'd3, 2'd0, 24'hAAAAAA, 1'b0, 12'h000},
    '{2'd1, 2'd3, 24'h0F0F0F, 1'b0, 12'h000},
    '{2'd3, 2'd1, 24'hF0F0F0, 1'b0, 12'h000},
    '{2'd2, 2'd1, 24'h7FFFFE, 1'b0, 12'h000},
    '{2'd1, 2'd2, 24'h000000, 1'b1, 12'h000},
    '{2'd2, 2'd3, 24'hC00003, 1'b0, 12'h000},
    '{2'd3, 2'd2, 24'h3C3C3C, 1'b0, 12'h000},
    '{2'd2, 2'd2, 24'h924924, 1'b0, 12'h000},
    '{2'd2, 2'd2, 24'h6DB6DB, 1'b0, 12'h000},
    '{2'd3, 2'd3, 24'hFFFFFF, 1'b1, 12'hFFF},
    '{2'd3, 2'd3, 24'h800000, 1'b0, 12'h000},
    '{2'd2, 2'd2, 24'h000001, 1'b0, 12'h000},
    '{2'd2, 2'd2, 24'hFFFFFF, 1'b1, 12'hFFF}
  };

  logic               clk;
  logic               rst_n;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [PDATA_W-1:0] cfg_pwdata;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  bgu_in_if  in_ch ();
  bgu_out_if out_ch ();

  bitmap_glyph_upscaler_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  logic [FACTOR_W-1:0]   x_reg = 2'd2;
  logic [FACTOR_W-1:0]   y_reg = 2'd2;
  logic [SRC_CNT_W-1:0]  src_row = '0;
  logic [OROW_W-1:0]     out_row = '0;
  chunk_t                exp_chunks [$];
  int                    errors = 0;
  int unsigned           cycles = 0;

  logic                  row_fixed;
  logic [CHUNK_BITS-1:0] row_fixed_chunk;
  bit                    tx_steady = 1'b0;
  bit                    rx_steady = 1'b0;
  bit                    hold_off_req = 1'b0;
  bit                    rx_hold_done = 1'b0;
  int unsigned           rx_hold_left = 0;
  logic [FACTOR_W-1:0]   cur_x = 2'd2;
  logic [FACTOR_W-1:0]   cur_y = 2'd2;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic upscale_row(input logic [ROW_W-1:0] row, input logic fixed,
                             input logic [CHUNK_BITS-1:0] fchunk);
    int     xf;
    int     yf;
    int     r;
    int     total;
    int     first;
    int     stop;
    int     width;
    int     chunks;
    int     n;
    int     n_total;
    int     j;
    int     sc;
    chunk_t res;
    xf = (x_reg == 2'd0) ? 1 : int'(x_reg);
    yf = (y_reg == 2'd0) ? 1 : int'(y_reg);
    r = int'(src_row) % SOURCE_SIZE;
    total = (3 * yf * SOURCE_SIZE) / 2;
    first = (3 * yf * r + 1) / 2;
    stop = (3 * yf * (r + 1) + 1) / 2;
    if (stop > total) stop = total;
    width = (3 * xf * SOURCE_SIZE) / 2;
    chunks = (width + CHUNK_BITS - 1) / CHUNK_BITS;
    n_total = (stop > first) ? (stop - first) * chunks : 0;
    if (n_total > MAX_CHUNKS) n_total = MAX_CHUNKS;
    n = 0;
    for (int orow = first; orow < stop && n < MAX_CHUNKS; orow++) begin
      for (int c = 0; c < chunks && n < MAX_CHUNKS; c++) begin
        res = '0;
        for (int b = 0; b < CHUNK_BITS; b++) begin
          j = c * CHUNK_BITS + b;
          if (j < width) begin
            sc = (2 * j) / (3 * xf);
            if (sc < SOURCE_SIZE) res.pixel_chunk[CHUNK_BITS-1-b] = row[SOURCE_SIZE-1-sc];
          end
        end
        if (fixed) res.pixel_chunk = fchunk;
        res.row_end = (c + 1 == chunks);
        res.image_end = res.row_end && (orow + 1 == total);
        res.last = (n + 1 == n_total);
        exp_chunks.push_back(res);
        n++;
      end
    end
    if (r + 1 >= SOURCE_SIZE) begin
      src_row = '0;
      out_row = '0;
    end else begin
      src_row = SRC_CNT_W'(r + 1);
      out_row = OROW_W'(stop);
    end
  endtask

  task automatic check_field(input string name, input logic [CHUNK_BITS-1:0] want,
                             input logic [CHUNK_BITS-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    chunk_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (exp_chunks.size() == 0) begin
          $error("pixel_chunk: expected none, got 0x%0h", out_ch.pixel_chunk);
          errors++;
        end else begin
          want = exp_chunks.pop_front();
          check_field("pixel_chunk", want.pixel_chunk, out_ch.pixel_chunk);
          check_field("row_end", 12'(want.row_end), 12'(out_ch.row_end));
          check_field("image_end", 12'(want.image_end), 12'(out_ch.image_end));
          check_field("last", 12'(want.last), 12'(out_ch.last));
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr)
          ADDR_X:  x_reg = cfg_pwdata[FACTOR_W-1:0];
          ADDR_Y:  y_reg = cfg_pwdata[FACTOR_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) upscale_row(in_ch.row_bits, row_fixed, row_fixed_chunk);
    end
  end

  always @(posedge clk) begin
    if (hold_off_req && !rx_hold_done) begin
      rx_hold_done = 1'b1;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ch.ready <= 1'b0;
    end else if (rx_steady) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= 32);
    end
  end

  task automatic send_row(input logic [ROW_W-1:0] row, input logic fixed,
                          input logic [CHUNK_BITS-1:0] fchunk);
    if (!tx_steady && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 32);
    end
    in_ch.valid <= 1'b1;
    in_ch.row_bits <= row;
    row_fixed <= fixed;
    row_fixed_chunk <= fchunk;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (exp_chunks.size() != 0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [FACTOR_W-1:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= PADDR_W'(4 * int'(idx));
    cfg_pwdata <= {30'($urandom()), val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic write_factors(input logic [FACTOR_W-1:0] xv, input logic [FACTOR_W-1:0] yv);
    write_reg(REG_X_FACTOR, xv);
    write_reg(REG_Y_FACTOR, yv);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cur_x = xv;
    cur_y = yv;
  endtask

  initial begin
    int                  sent;
    int                  phase;
    int                  burst;
    logic [ROW_W-1:0]    row;
    logic [FACTOR_W-1:0] xv;
    logic [FACTOR_W-1:0] yv;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.row_bits = '0;
    out_ch.ready = 1'b0;
    row_fixed = 1'b0;
    row_fixed_chunk = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].xf != cur_x || dir_tab[i].yf != cur_y) begin
        drain();
        write_factors(dir_tab[i].xf, dir_tab[i].yf);
      end
      send_row(dir_tab[i].row, dir_tab[i].fixed, dir_tab[i].chunk);
    end

    sent = 0;
    phase = 0;
    while (sent < RAND_ROWS) begin
      drain();
      case (phase)
        0: begin xv = 2'd3; yv = 2'd3; end
        1: begin xv = 2'd1; yv = 2'd1; end
        2: begin xv = 2'd0; yv = 2'd0; end
        default: begin xv = FACTOR_W'($urandom()); yv = FACTOR_W'($urandom()); end
      endcase
      write_factors(xv, yv);
      tx_steady = (phase == 3);
      rx_steady = (phase == 3);
      if (phase == 0) hold_off_req = 1'b1;
      burst = (phase == 0) ? 30 : $urandom_range(40, 10);
      if (burst > RAND_ROWS - sent) burst = RAND_ROWS - sent;
      repeat (burst) begin
        case ($urandom_range(9))
          0:       row = '0;
          1:       row = '1;
          2:       row = ROW_W'(1) << $urandom_range(ROW_W-1);
          3:       row = ~(ROW_W'(1) << $urandom_range(ROW_W-1));
          default: row = ROW_W'($urandom());
        endcase
        send_row(row, 1'b0, '0);
        sent++;
      end
      phase++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
